// File: design/pws_pkg.sv
package pws_pkg;

    localparam int PHASE_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAW      = 2'd3
    } wave_kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

    typedef struct packed {
        wave_kind_t          kind;
        logic [AMP_W-1:0]    amplitude;
    } shape_cfg_t;

    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

// File: design/pws_divstep.sv
// One restoring division step: shift in a bit, subtract divisor if it fits.
module pws_divstep import pws_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  stage_ctl_t           ctl,
    input  logic [PERIOD_W-1:0]  in_rem,
    input  logic                 in_bit,
    input  logic [CW-1:0]        in_carry,
    input  logic [PERIOD_W-1:0]  divisor,
    output logic                 out_valid,
    output logic [PERIOD_W-1:0]  out_rem,
    output logic                 out_qbit,
    output logic [CW-1:0]        out_carry
);

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                fits;
    logic                valid_reg, valid_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic                qbit_reg;
    logic [CW-1:0]       carry_reg;

    assign trial = {in_rem, in_bit};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});
    assign rem_next   = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    assign valid_next = ctl.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rem_reg   <= rem_next;
            qbit_reg  <= fits;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_qbit  = qbit_reg;
    assign out_carry = carry_reg;

endmodule

// File: design/pws_shape.sv
// Waveform evaluation: table/operand select, amplitude multiply, scale.
module pws_shape import pws_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stage_ctl_t                 ctl,
    input  logic [PHASE_W-1:0]         phase_frac,
    input  shape_cfg_t                 cfg,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_sample
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int QW = AW - 2;
    localparam int QD = SINE_TABLE_DEPTH / 4;
    localparam real TWO_PI = 6.283185307179586476925;

    // first quarter of the sine; the rest is folded from it
    logic signed [SAMPLE_W-1:0] sine_rom [QD];

    for (genvar k = 0; k < QD; k++) begin : g_rom
        localparam real V = 32767.0 * $sin(TWO_PI * k / SINE_TABLE_DEPTH);
        localparam int  R = (V >= 0.0) ? $rtoi(V + 0.5) : -$rtoi(0.5 - V);
        assign sine_rom[k] = SAMPLE_W'(R);
    end

    logic [AW-1:0]        rom_idx;
    logic [QW-1:0]        q_low, q_idx;
    logic                 q_mirror, q_neg, q_peak;
    logic signed [SAMPLE_W-1:0] q_mag, sine_val;
    logic signed [19:0]   f4, tri_lo, tri_hi, saw;
    logic signed [17:0]   opnd_next;

    assign rom_idx  = phase_frac[PHASE_W-1 -: AW];
    assign q_low    = rom_idx[QW-1:0];
    assign q_mirror = rom_idx[AW-2];
    assign q_neg    = rom_idx[AW-1];
    assign q_idx    = q_mirror ? QW'(-q_low) : q_low;
    // mirrored quadrant start lands on the quarter-period peak
    assign q_peak   = q_mirror && (q_low == '0);
    assign q_mag    = q_peak ? SAMPLE_W'(32767) : sine_rom[q_idx];
    assign sine_val = q_neg ? -q_mag : q_mag;

    assign f4      = signed'({2'b00, phase_frac, 2'b00});
    assign tri_lo  = f4 - 20'sd65536;
    assign tri_hi  = 20'sd196608 - f4;
    assign saw     = signed'({3'b000, phase_frac, 1'b0}) - 20'sd65536;

    always_comb begin
        case (cfg.kind)
            WAVE_SINE:     opnd_next = 18'(sine_val);
            WAVE_TRIANGLE: opnd_next = phase_frac[PHASE_W-1] ? tri_hi[17:0] : tri_lo[17:0];
            default:       opnd_next = saw[17:0];
        endcase
    end

    // stage 1: operand
    logic                v1_reg, v2_reg, v3_reg;
    logic signed [17:0]  opnd1_reg;
    wave_kind_t          kind1_reg, kind2_reg;
    logic                neg1_reg, neg2_reg;
    // stage 2: product
    logic signed [33:0]  prod2_reg;
    logic signed [SAMPLE_W-1:0] sample3_reg, sample3_next;
    logic signed [SAMPLE_W-1:0] amp_s;

    assign amp_s = signed'({1'b0, cfg.amplitude});

    always_comb begin
        case (kind2_reg)
            WAVE_SQUARE: sample3_next = neg2_reg ? -amp_s : amp_s;
            WAVE_SINE:   sample3_next = SAMPLE_W'(prod2_reg >>> 15);
            default:     sample3_next = SAMPLE_W'(prod2_reg >>> 16);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ctl.en) begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            opnd1_reg   <= opnd_next;
            kind1_reg   <= cfg.kind;
            neg1_reg    <= phase_frac[PHASE_W-1];
            prod2_reg   <= amp_s * opnd1_reg;
            kind2_reg   <= kind1_reg;
            neg2_reg    <= neg1_reg;
            sample3_reg <= sample3_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_sample = sample3_reg;

endmodule

// File: design/periodic_waveform_sample_top.sv
// Channel  | Ports                      | Content
// ---------+----------------------------+--------------------------------------
// input    | s_tvalid s_tready s_tdata  | time_ticks [31:0]
// result   | m_tvalid m_tready m_tdata  | sample_value [15:0], two's complement
// config   | cfg_valid cfg_ready        | cfg_index (0 wave_kind, 1 amplitude,
//          | cfg_index cfg_data         | 2 period_ticks), cfg_data [15:0]
//
// One sample per clock sustained while m_tready stays high. Stages in order:
// input register, TIME_WIDTH restoring steps for time mod period, 16 steps
// for the phase fraction, then operand/table, multiply and scale stages.
// aresetn (sync, active low) empties the pipe and restores register defaults.
// The whole pipe holds while the result register waits on m_tready.
module periodic_waveform_sample_top import pws_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int TIME_WIDTH       = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] time_ticks
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] sample_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    // ---- configuration registers ----
    wave_kind_t          kind_reg;
    logic [AMP_W-1:0]    amp_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] divisor;   // period of zero acts as one

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= WAVE_SINE;
            amp_reg    <= '0;
            period_reg <= 16'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WAVE_KIND: kind_reg   <= wave_kind_t'(cfg_data[1:0]);
                REG_AMPLITUDE: amp_reg    <= cfg_data[AMP_W-1:0];
                REG_PERIOD:    period_reg <= cfg_data;
                default:       ;   // unused index, write dropped
            endcase
        end
    end

    assign divisor = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    // ---- global advance: hold everything while the result is not taken ----
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---- input register ----
    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] time_ext;

    if (TIME_WIDTH <= 32) begin : g_trunc
        assign time_ext = s_tdata[TIME_WIDTH-1:0];
    end else begin : g_zext
        assign time_ext = {{(TIME_WIDTH-32){1'b0}}, s_tdata};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            time_reg <= time_ext;
        end
    end

    // ---- time mod period: one time bit per stage, MSB first ----
    logic                  mod_valid [TIME_WIDTH+1];
    logic [PERIOD_W-1:0]   mod_rem   [TIME_WIDTH+1];
    logic [TIME_WIDTH-1:0] mod_time  [TIME_WIDTH+1];

    assign mod_valid[0] = in_valid_reg;
    assign mod_rem[0]   = '0;
    assign mod_time[0]  = time_reg;

    for (genvar i = 0; i < TIME_WIDTH; i++) begin : g_mod
        logic unused_q;
        pws_divstep #(.CW(TIME_WIDTH)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       ('{en: en, valid: mod_valid[i]}),
            .in_rem    (mod_rem[i]),
            .in_bit    (mod_time[i][TIME_WIDTH-1-i]),
            .in_carry  (mod_time[i]),
            .divisor   (divisor),
            .out_valid (mod_valid[i+1]),
            .out_rem   (mod_rem[i+1]),
            .out_qbit  (unused_q),
            .out_carry (mod_time[i+1])
        );
    end

    // ---- phase fraction: (phase << 16) / period, one quotient bit per stage ----
    logic                div_valid [PHASE_W+1];
    logic [PERIOD_W-1:0] div_rem   [PHASE_W+1];
    logic [PHASE_W-1:0]  div_quot  [PHASE_W+1];

    assign div_valid[0] = mod_valid[TIME_WIDTH];
    assign div_rem[0]   = mod_rem[TIME_WIDTH];
    assign div_quot[0]  = '0;

    for (genvar j = 0; j < PHASE_W; j++) begin : g_div
        logic                qbit;
        logic [PHASE_W-1:0]  quot_prev;
        pws_divstep #(.CW(PHASE_W)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       ('{en: en, valid: div_valid[j]}),
            .in_rem    (div_rem[j]),
            .in_bit    (1'b0),
            .in_carry  (div_quot[j]),
            .divisor   (divisor),
            .out_valid (div_valid[j+1]),
            .out_rem   (div_rem[j+1]),
            .out_qbit  (qbit),
            .out_carry (quot_prev)
        );
        assign div_quot[j+1] = {quot_prev[PHASE_W-2:0], qbit};
    end

    // ---- waveform shaping ----
    logic signed [SAMPLE_W-1:0] sample;

    pws_shape #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_shape (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        ('{en: en, valid: div_valid[PHASE_W]}),
        .phase_frac (div_quot[PHASE_W]),
        .cfg        ('{kind: kind_reg, amplitude: amp_reg}),
        .out_valid  (m_tvalid),
        .out_sample (sample)
    );

    assign m_tdata = sample;

    // ---- assertions ----
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(div_valid[PHASE_W]) && $stable(div_quot[PHASE_W]))
        else $error("pipe moved during output stall");

    a_no_min_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("sample outside +/-32767");

endmodule
